>>> rtl/core/esmm_pkg.sv
// ----------------------------------------------------------------------------
// esmm_pkg: shared types and constants of the escape-sequence multi-matcher
// Pattern ROM, pattern lengths, group layout, operation and level codes.
// ----------------------------------------------------------------------------
package esmm_pkg;

	localparam int NUM_PATTERNS = 18;
	localparam int PAT_LEN_MAX  = 32;
	localparam int NUM_GROUPS   = 3;
	localparam int POS_W        = 5;
	localparam int LEN_W        = 6;
	localparam int IDX_W        = 4;

	// wildcard codes inside pattern text, and the linefeed code
	localparam logic [7:0] WILD_DIGITS = 8'h05;
	localparam logic [7:0] WILD_PRINT  = 8'h06;
	localparam logic [7:0] WILD_NOT_LF = 8'h04;
	localparam logic [7:0] CHR_LF      = 8'h0A;

	typedef enum logic [1:0] {
		OP_STEP   = 2'd0,
		OP_ENABLE = 2'd1,
		OP_REWIND = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		PL_PROMPT = 2'd0,
		PL_EXEC   = 2'd1,
		PL_EAT    = 2'd2
	} level_t;

	// pattern text, right-justified: first byte sits highest
	typedef logic [8*PAT_LEN_MAX-1:0] pat_word_t;

	localparam pat_word_t PAT_ROM [NUM_PATTERNS] = '{
		"\033[0;30m\033[0m\033[1;37m\033[0m",
		"\033[0;34m\033[0m\033[0;31m\033[0m",
		" \015",
		"\033[\005C",
		"\010",
		"\033[\005K",
		"\033[\005P",
		"\033[\005@",
		"\033[\005D",
		"\007",
		"\033[\005A",
		"\015\004",
		"\015\n",
		"\033P",
		"\033[0;30m\033[0m\033[1;37m\033[0m",
		"\033[0;34m\033[0m\033[0;31m\033[0m",
		"\033P",
		"\006\033\\"
	};

	localparam logic [LEN_W-1:0] PAT_LEN [NUM_PATTERNS] = '{
		6'd22, 6'd22, 6'd2, 6'd4, 6'd1, 6'd4, 6'd4, 6'd4, 6'd4,
		6'd1, 6'd4, 6'd2, 6'd2, 6'd2, 6'd22, 6'd22, 6'd2, 6'd3
	};

	localparam int GRP_FIRST [NUM_GROUPS] = '{0, 14, 17};
	localparam int GRP_COUNT [NUM_GROUPS] = '{14, 3, 1};

	// result of stepping one pattern
	typedef struct packed {
		logic             busy;
		logic             done;
		logic             en_nx;
		logic [POS_W-1:0] pos_nx;
	} pat_res_t;

	// word produced for one item
	typedef struct packed {
		logic             in_progress;
		logic             matched;
		logic [IDX_W-1:0] matched_index;
	} res_t;

	function automatic logic [NUM_PATTERNS-1:0] group_mask(int g);
		logic [NUM_PATTERNS-1:0] m;
		m = '0;
		for (int k = 0; k < NUM_PATTERNS; k++) begin
			if (k >= GRP_FIRST[g] && k < GRP_FIRST[g] + GRP_COUNT[g])
				m[k] = 1'b1;
		end
		return m;
	endfunction

	function automatic logic [IDX_W-1:0] local_index(int k);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (k >= GRP_FIRST[g] && k < GRP_FIRST[g] + GRP_COUNT[g])
				r = IDX_W'(k - GRP_FIRST[g]);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/esmm_pat_step.sv
// ----------------------------------------------------------------------------
// esmm_pat_step: one-byte step of a single ROM pattern
// Works out the next position, enable and status of one pattern.
// ----------------------------------------------------------------------------
module esmm_pat_step #(
	parameter int PAT_ID = 0
) (
	input  logic                         en,
	input  logic [esmm_pkg::POS_W-1:0]   pos,
	input  logic [7:0]                   byte_in,
	output esmm_pkg::pat_res_t           res
);

	localparam logic [esmm_pkg::LEN_W-1:0] LEN  = esmm_pkg::PAT_LEN[PAT_ID];
	localparam esmm_pkg::pat_word_t        WORD = esmm_pkg::PAT_ROM[PAT_ID];

	logic [esmm_pkg::POS_W-1:0] posv;
	logic [esmm_pkg::LEN_W-1:0] rev;
	logic [esmm_pkg::LEN_W-1:0] rev_m1;
	logic [esmm_pkg::LEN_W-1:0] adv;
	logic [7:0]                 cur;
	logic [7:0]                 delim;
	logic                       in_run;
	logic                       fail;

	always_comb begin
		// out-of-range position counts as the start
		posv   = ({1'b0, pos} >= LEN) ? '0 : pos;
		rev    = LEN - 6'd1 - {1'b0, posv};
		rev_m1 = rev - 6'd1;
		cur    = WORD[{rev[4:0], 3'b000} +: 8];
		delim  = (rev != '0) ? WORD[{rev_m1[4:0], 3'b000} +: 8] : 8'h00;
		in_run = 1'b0;
		fail   = 1'b0;
		adv    = {1'b0, posv} + 6'd1;

		if (cur == esmm_pkg::WILD_DIGITS || cur == esmm_pkg::WILD_PRINT) begin
			in_run = (cur == esmm_pkg::WILD_DIGITS) ?
				(byte_in >= 8'h30 && byte_in <= 8'h39) :
				(byte_in >= 8'h20 && byte_in <= 8'h7E);
			adv  = {1'b0, posv} + 6'd2;
			fail = (delim != byte_in);
		end else if (cur == esmm_pkg::WILD_NOT_LF) begin
			fail = (byte_in == esmm_pkg::CHR_LF);
		end else begin
			fail = (cur != byte_in);
		end

		res.busy   = 1'b0;
		res.done   = 1'b0;
		res.en_nx  = en;
		res.pos_nx = pos;
		if (en) begin
			if (in_run) begin
				res.busy = 1'b1;
			end else if (fail) begin
				res.en_nx  = 1'b0;
				res.pos_nx = '0;
			end else if (adv >= LEN) begin
				res.done   = 1'b1;
				res.pos_nx = '0;
			end else begin
				res.busy   = 1'b1;
				res.pos_nx = adv[esmm_pkg::POS_W-1:0];
			end
		end
	end

endmodule

>>> rtl/core/esmm_matcher.sv
// ----------------------------------------------------------------------------
// esmm_matcher: pattern state, parallel steppers and priority pick
// Holds position and enable of every pattern and applies one operation.
// ----------------------------------------------------------------------------
module esmm_matcher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [1:0]          op,
	input  logic [1:0]          pl,
	input  logic [7:0]          byte_in,
	output esmm_pkg::res_t      res
);

	localparam int N = esmm_pkg::NUM_PATTERNS;

	localparam logic [N-1:0] MASK_PROMPT = esmm_pkg::group_mask(0);
	localparam logic [N-1:0] MASK_EXEC   = esmm_pkg::group_mask(1);
	localparam logic [N-1:0] MASK_EAT    = esmm_pkg::group_mask(2);

	logic [esmm_pkg::POS_W-1:0] pos_q [N];
	logic [N-1:0]               en_q;
	logic [esmm_pkg::POS_W-1:0] pos_d [N];
	logic [N-1:0]               en_d;

	esmm_pkg::pat_res_t         pr [N];
	logic [esmm_pkg::IDX_W-1:0] lidx [N];
	logic [N-1:0]               grp;
	logic [N-1:0]               done_g;
	logic [N-1:0]               stepped;
	logic [N-1:0]               first_hot;
	logic                       op_ok;

	for (genvar k = 0; k < N; k++) begin : g_pat
		esmm_pat_step #(.PAT_ID(k)) u_step (
			.en      (en_q[k]),
			.pos     (pos_q[k]),
			.byte_in (byte_in),
			.res     (pr[k])
		);
		assign lidx[k] = esmm_pkg::local_index(k);
	end

	always_comb begin
		op_ok = (op == esmm_pkg::OP_STEP || op == esmm_pkg::OP_ENABLE ||
			op == esmm_pkg::OP_REWIND);
		case (pl)
			esmm_pkg::PL_PROMPT: grp = MASK_PROMPT;
			esmm_pkg::PL_EXEC:   grp = MASK_EXEC;
			esmm_pkg::PL_EAT:    grp = MASK_EAT;
			default:             grp = '0;
		endcase
		if (!op_ok)
			grp = '0;

		for (int k = 0; k < N; k++)
			done_g[k] = grp[k] & pr[k].done;

		// a pattern is skipped once an earlier one in its group completed
		for (int k = 0; k < N; k++) begin
			stepped[k]   = grp[k] & ~(|(done_g & ({N{1'b1}} >> (N - k))));
			first_hot[k] = stepped[k] & pr[k].done;
		end

		res = '0;
		if (op == esmm_pkg::OP_STEP) begin
			res.matched = |first_hot;
			for (int k = 0; k < N; k++) begin
				res.in_progress = res.in_progress | (stepped[k] & pr[k].busy);
				if (first_hot[k])
					res.matched_index = res.matched_index | lidx[k];
			end
		end

		for (int k = 0; k < N; k++) begin
			pos_d[k] = pos_q[k];
			en_d[k]  = en_q[k];
			if (go && grp[k]) begin
				case (op)
					esmm_pkg::OP_STEP: begin
						if (stepped[k]) begin
							pos_d[k] = pr[k].pos_nx;
							en_d[k]  = pr[k].en_nx;
						end
					end
					esmm_pkg::OP_ENABLE: en_d[k]  = 1'b1;
					esmm_pkg::OP_REWIND: pos_d[k] = '0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			for (int k = 0; k < N; k++)
				pos_q[k] <= '0;
		end else begin
			en_q <= en_d;
			for (int k = 0; k < N; k++)
				pos_q[k] <= pos_d[k];
		end
	end

	// at most one pattern wins the priority pick
	a_one_winner: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_hot))
		else $error("esmm: more than one completing pattern picked");

	for (genvar k = 0; k < N; k++) begin : g_chk
		// failing resets the position, so a disabled pattern sits at the start
		a_off_at_start: assert property (@(posedge clk) disable iff (!arst_n)
			!en_q[k] |-> pos_q[k] == '0)
			else $error("esmm: disabled pattern with non-zero position");

		a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
			{1'b0, pos_q[k]} < esmm_pkg::PAT_LEN[k])
			else $error("esmm: pattern position beyond pattern end");
	end

endmodule

>>> rtl/core/escape_sequence_multi_matcher.sv
// ----------------------------------------------------------------------------
// escape_sequence_multi_matcher: terminal escape-sequence matcher
// Applies a step, enable or rewind to the chosen pattern group; a step feeds
// one byte and reports the first pattern that completed, with an in-progress flag.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | fields
//  --------+--------------------+------------------------------------------
//  in      | in_valid, in_stall | operation, pattern_group, byte_in
//  out     | out_valid,out_stall| in_progress, matched, matched_index
//
// One word is taken per cycle unless in_stall holds it. A result word is offered
// on out once it is loaded into the result register (input register, then one
// combinational pass through all pattern steppers and the priority pick into
// the result register).
// Pattern state updates on the same edge that loads the result register.
// arst_n clears every position and enable (all patterns disabled) and empties
// both registers. A stall on out holds the result and backs up into in_stall
// only when the result register is full and the input register holds a word.
// ----------------------------------------------------------------------------
module escape_sequence_multi_matcher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [1:0]                    pattern_group,
	input  logic [7:0]                    byte_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          in_progress,
	output logic                          matched,
	output logic [esmm_pkg::IDX_W-1:0]    matched_index
);

	// input register
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [1:0] pl_s1;
	logic [7:0] byte_s1;

	// result register
	logic           valid_s2;
	esmm_pkg::res_t res_s2;

	esmm_pkg::res_t res_c;
	logic           adv_s1;

	// the input word moves on when the result register is free or draining
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	esmm_matcher u_matcher (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (adv_s1),
		.op      (op_s1),
		.pl      (pl_s1),
		.byte_in (byte_s1),
		.res     (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			pl_s1   <= pattern_group;
			byte_s1 <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid     = valid_s2;
	assign in_progress   = res_s2.in_progress;
	assign matched       = res_s2.matched;
	assign matched_index = res_s2.matched_index;

	// no match means the index field is zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.matched |-> res_s2.matched_index == '0)
		else $error("esmm: index set without a match");

	// only a byte step may report progress or a match
	a_step_only: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 != esmm_pkg::OP_STEP |=> !res_s2.matched && !res_s2.in_progress)
		else $error("esmm: status reported on a non-step word");

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_s2))
		else $error("esmm: stalled result word changed");

endmodule

>>> test/esmm_stream_checker.sv
// ----------------------------------------------------------------------------
// esmm_stream_checker: result predictor and scoreboard of the matcher
// Mirrors the pattern positions and enables, predicts one result word for
// each word taken on the input channel and compares it with the output.
// ----------------------------------------------------------------------------
module esmm_stream_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [1:0]                 operation,
	input  logic [1:0]                 pattern_group,
	input  logic [7:0]                 byte_in,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       in_progress,
	input  logic                       matched,
	input  logic [esmm_pkg::IDX_W-1:0] matched_index,
	output int                         fail_count,
	output int                         pending
);

	localparam int MAX_REPORTS = 10;

	logic [esmm_pkg::POS_W-1:0] pat_pos [esmm_pkg::NUM_PATTERNS];
	bit                         pat_on  [esmm_pkg::NUM_PATTERNS];
	esmm_pkg::res_t             awaiting [$];
	int                         fails = 0;

	assign fail_count = fails;

	// byte i of pattern k, counted from the start of the text
	function automatic logic [7:0] rom_byte(int k, int i);
		return esmm_pkg::PAT_ROM[k][8*(int'(esmm_pkg::PAT_LEN[k]) - 1 - i) +: 8];
	endfunction

	function automatic esmm_pkg::res_t predict_word(logic [1:0] op, logic [1:0] lvl,
			logic [7:0] c);
		esmm_pkg::res_t r;
		logic           busy, done, fail, run;
		logic [7:0]     p, delim;
		int             k, len, pos;
		r    = '0;
		busy = 1'b0;
		done = 1'b0;
		if (lvl > esmm_pkg::PL_EAT || op > esmm_pkg::OP_REWIND)
			return r;
		for (int i = 0; i < esmm_pkg::GRP_COUNT[lvl] && !done; i++) begin
			k = esmm_pkg::GRP_FIRST[lvl] + i;
			case (op)
				esmm_pkg::OP_ENABLE: pat_on[k] = 1'b1;
				esmm_pkg::OP_REWIND: pat_pos[k] = '0;
				default: begin
					if (pat_on[k]) begin
						len = int'(esmm_pkg::PAT_LEN[k]);
						pos = int'(pat_pos[k]);
						if (pos >= len)
							pos = 0;
						p     = rom_byte(k, pos);
						delim = (pos + 1 < len) ? rom_byte(k, pos + 1) : 8'h00;
						fail  = 1'b0;
						run   = 1'b0;
						if (p == esmm_pkg::WILD_DIGITS || p == esmm_pkg::WILD_PRINT) begin
							run = (p == esmm_pkg::WILD_DIGITS) ?
								(c >= 8'h30 && c <= 8'h39) :
								(c >= 8'h20 && c <= 8'h7E);
							if (!run) begin
								if (c == delim)
									pos += 2;
								else
									fail = 1'b1;
							end
						end else if (p == esmm_pkg::WILD_NOT_LF) begin
							if (c == esmm_pkg::CHR_LF)
								fail = 1'b1;
							else
								pos++;
						end else if (p == c) begin
							pos++;
						end else begin
							fail = 1'b1;
						end
						if (run) begin
							busy = 1'b1;
						end else if (fail) begin
							pat_pos[k] = '0;
							pat_on[k]  = 1'b0;
						end else if (pos >= len) begin
							pat_pos[k]      = '0;
							done            = 1'b1;
							r.matched_index = esmm_pkg::IDX_W'(i);
						end else begin
							pat_pos[k] = esmm_pkg::POS_W'(pos);
							busy       = 1'b1;
						end
					end
				end
			endcase
		end
		if (op == esmm_pkg::OP_STEP) begin
			r.in_progress = busy;
			r.matched     = done;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		esmm_pkg::res_t want, got;
		if (!arst_n) begin
			for (int k = 0; k < esmm_pkg::NUM_PATTERNS; k++) begin
				pat_pos[k] = '0;
				pat_on[k]  = 1'b0;
			end
			awaiting.delete();
			pending <= 0;
		end else begin
			got = '{in_progress, matched, matched_index};
			if (out_valid && !out_stall) begin
				if (awaiting.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("unexpected result word: ip=%0b m=%0b idx=%0d",
							got.in_progress, got.matched, got.matched_index);
				end else begin
					want = awaiting.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= MAX_REPORTS)
							$display("mismatch: want ip=%0b m=%0b idx=%0d, %s%0b m=%0b idx=%0d",
								want.in_progress, want.matched, want.matched_index,
								"got ip=", got.in_progress, got.matched,
								got.matched_index);
					end
				end
			end
			if (in_valid && !in_stall)
				awaiting.push_back(predict_word(operation, pattern_group, byte_in));
			pending <= awaiting.size();
		end
	end

endmodule

>>> test/escape_sequence_multi_matcher_tb.sv
// ----------------------------------------------------------------------------
// escape_sequence_multi_matcher_tb: stimulus and verdict for the matcher
// Directed words first, then random escape sequences, noise and group
// operations under several idle/stall mixes; the checker scores results.
// ----------------------------------------------------------------------------
module escape_sequence_multi_matcher_tb;

	// codes outside the defined ranges, and two control characters
	localparam logic [1:0] OP_BAD  = 2'd3;
	localparam logic [1:0] LVL_BAD = 2'd3;
	localparam logic [7:0] CHR_ESC = 8'h1B;
	localparam logic [7:0] CHR_CR  = 8'h0D;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 20;
	localparam int PHASE_ITEMS    = 440;
	localparam int PRESSURE_ITEMS = 30;
	localparam int NUM_PHASES     = 4;
	localparam int IDLE_PCT  [NUM_PHASES] = '{0, 48, 0, 15};
	localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 48, 15};

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 operation;
	logic [1:0]                 pattern_group;
	logic [7:0]                 byte_in;
	logic                       out_valid;
	logic                       out_stall;
	logic                       in_progress;
	logic                       matched;
	logic [esmm_pkg::IDX_W-1:0] matched_index;

	int          fail_count;
	int          pending;
	int          idle_pct   = 0;
	int          stall_pct  = 0;
	int          hold_token = 0;
	int          items_sent = 0;
	int unsigned cycles     = 0;

	escape_sequence_multi_matcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.pattern_group (pattern_group),
		.byte_in       (byte_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.in_progress   (in_progress),
		.matched       (matched),
		.matched_index (matched_index)
	);

	esmm_stream_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.pattern_group (pattern_group),
		.byte_in       (byte_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.in_progress   (in_progress),
		.matched       (matched),
		.matched_index (matched_index),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stall, or a long hold-off each time the token moves
	initial begin
		int hold_left = 0;
		int hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// Offer one word and hold it until taken. Random idle cycles go first;
	// valid stays high between back-to-back words.
	task automatic offer_word(input logic [1:0] op, input logic [1:0] lvl,
			input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		pattern_group <= lvl;
		byte_in       <= b;
		do @(posedge clk); while (in_stall);
		// words on a bad op or level change no pattern state and are not counted
		if (op <= esmm_pkg::OP_REWIND && lvl <= esmm_pkg::PL_EAT)
			items_sent++;
	endtask

	// Sender pause: wait until every result word has come back.
	// pending is registered, so the loop waits for an edge before it looks.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// One burst: mostly a whole pattern of the group with random wildcard
	// content and the odd corrupted byte, otherwise noise or group ops.
	task automatic play_sequence();
		int         roll, pick, k, len;
		logic [1:0] lvl;
		logic [7:0] pb, c;
		roll = $urandom_range(99);
		pick = $urandom_range(99);
		if (pick < 70)
			lvl = esmm_pkg::PL_PROMPT;
		else if (pick < 85)
			lvl = esmm_pkg::PL_EXEC;
		else if (pick < 97)
			lvl = esmm_pkg::PL_EAT;
		else
			lvl = LVL_BAD;
		if (roll < 75 && lvl != LVL_BAD) begin
			if ($urandom_range(99) < 70)
				offer_word(esmm_pkg::OP_ENABLE, lvl, 8'($urandom));
			k   = esmm_pkg::GRP_FIRST[lvl] + $urandom_range(esmm_pkg::GRP_COUNT[lvl] - 1);
			len = int'(esmm_pkg::PAT_LEN[k]);
			for (int i = 0; i < len; i++) begin
				pb = esmm_pkg::PAT_ROM[k][8*(len - 1 - i) +: 8];
				if ($urandom_range(99) < 8) begin
					c = 8'($urandom);
				end else if (pb == esmm_pkg::WILD_DIGITS) begin
					// digit run; the delimiter is the next pattern byte
					repeat ($urandom_range(3))
						offer_word(esmm_pkg::OP_STEP, lvl,
							8'($urandom_range(8'h39, 8'h30)));
					continue;
				end else if (pb == esmm_pkg::WILD_PRINT) begin
					repeat ($urandom_range(4))
						offer_word(esmm_pkg::OP_STEP, lvl,
							8'($urandom_range(8'h7E, 8'h20)));
					continue;
				end else if (pb == esmm_pkg::WILD_NOT_LF) begin
					do c = 8'($urandom); while (c == esmm_pkg::CHR_LF);
				end else begin
					c = pb;
				end
				offer_word(esmm_pkg::OP_STEP, lvl, c);
			end
		end else if (roll < 85) begin
			repeat ($urandom_range(4, 1))
				offer_word(esmm_pkg::OP_STEP, lvl, 8'($urandom));
		end else if (roll < 90) begin
			offer_word(esmm_pkg::OP_REWIND, lvl, 8'($urandom));
		end else if (roll < 95) begin
			offer_word(OP_BAD, 2'($urandom), 8'($urandom));
		end else begin
			offer_word(esmm_pkg::OP_ENABLE, lvl, 8'($urandom));
		end
	endtask

	task automatic stream_random(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target)
			play_sequence();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		operation     = esmm_pkg::OP_STEP;
		pattern_group = esmm_pkg::PL_PROMPT;
		byte_in       = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// everything disabled straight after reset
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, 8'h08);
		// unknown operation, unknown level: ignored
		offer_word(OP_BAD, esmm_pkg::PL_PROMPT, 8'h08);
		offer_word(esmm_pkg::OP_STEP, LVL_BAD, 8'hFF);
		// backspace
		offer_word(esmm_pkg::OP_ENABLE, esmm_pkg::PL_PROMPT, 8'hFF);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, 8'h08);
		// cursor forward with a digit run
		offer_word(esmm_pkg::OP_ENABLE, esmm_pkg::PL_PROMPT, 8'h00);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, CHR_ESC);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, "[");
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, "1");
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, "2");
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, "C");
		// space CR wins before the CR patterns are stepped
		offer_word(esmm_pkg::OP_ENABLE, esmm_pkg::PL_PROMPT, 8'h00);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, " ");
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, CHR_CR);
		// CR LF: the non-linefeed wildcard fails on LF
		offer_word(esmm_pkg::OP_ENABLE, esmm_pkg::PL_PROMPT, 8'h00);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, CHR_CR);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, esmm_pkg::CHR_LF);
		// ESC P while executing
		offer_word(esmm_pkg::OP_ENABLE, esmm_pkg::PL_EXEC, 8'h00);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_EXEC, CHR_ESC);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_EXEC, "P");
		// printable run then ESC backslash while eating
		offer_word(esmm_pkg::OP_ENABLE, esmm_pkg::PL_EAT, 8'h00);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_EAT, "~");
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_EAT, CHR_ESC);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_EAT, "\\");
		// rewind, then a zero byte
		offer_word(esmm_pkg::OP_REWIND, esmm_pkg::PL_PROMPT, 8'hFF);
		offer_word(esmm_pkg::OP_STEP, esmm_pkg::PL_PROMPT, 8'h00);
		drain();

		// --- random phases ---
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			idle_pct  = IDLE_PCT[ph];
			stall_pct <= STALL_PCT[ph];
			stream_random(PHASE_ITEMS);
			if (ph == 0 || ph == NUM_PHASES - 1) begin
				// long receiver hold-off while the sender keeps offering
				hold_token <= hold_token + 1;
				stream_random(PRESSURE_ITEMS);
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
